// ----- rtl/svam_pkg.sv -----
// Shared types and constants of the servo axis arm/move sequencer.
package svam_pkg;

    // Event codes carried in the action field
    localparam logic [2:0] ACT_TICK   = 3'd0;
    localparam logic [2:0] ACT_BEGIN  = 3'd1;
    localparam logic [2:0] ACT_ENABLE = 3'd2;
    localparam logic [2:0] ACT_DISABLE = 3'd3;
    localparam logic [2:0] ACT_MOVE   = 3'd4;
    localparam logic [2:0] ACT_STOP   = 3'd5;
    localparam logic [2:0] ACT_CLEAR  = 3'd6;

    // Configuration register indexes
    localparam logic [2:0] CFG_ZERO_OFFSET   = 3'd0;
    localparam logic [2:0] CFG_MIN_POSITION  = 3'd1;
    localparam logic [2:0] CFG_MAX_POSITION  = 3'd2;
    localparam logic [2:0] CFG_DEF_VELOCITY  = 3'd3;
    localparam logic [2:0] CFG_DEF_ACCEL     = 3'd4;
    localparam logic [2:0] CFG_DEF_DECEL     = 3'd5;

    // Drive modes of the published control word
    localparam logic [1:0] MODE_OFF    = 2'd0;
    localparam logic [1:0] MODE_HALT   = 2'd1;
    localparam logic [1:0] MODE_ENABLE = 2'd2;

    // Drive readiness code meaning "in operation"
    localparam logic [1:0] FB_IN_OPERATION = 2'd3;

    localparam int ARM_CNT_W   = 9;
    localparam int MOVE_CNT_W  = 3;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] target_pos;
        logic [30:0]        move_speed;
        logic [30:0]        move_accel;
        logic [30:0]        move_decel;
        logic               link_online;
        logic               fb_valid;
        logic [1:0]         fb_ready;
        logic               fb_not_following;
        logic               fb_reached;
        logic signed [31:0] fb_position;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         drive_mode;
        logic               clear_errors;
        logic               accept_level;
        logic signed [31:0] cmd_position;
        logic [30:0]        cmd_velocity;
        logic [30:0]        cmd_accel;
        logic [30:0]        cmd_decel;
        logic               accepted;
        logic               busy_res;
    } t_out_item;

    // Configuration register file contents
    typedef struct packed {
        logic signed [31:0] zero_offset;
        logic signed [31:0] min_position;
        logic signed [31:0] max_position;
        logic [30:0]        default_velocity;
        logic [30:0]        default_accel;
        logic [30:0]        default_decel;
    } t_cfg;

    // Event after classification: move profile resolved, target absolute
    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] abs_target;
        logic [30:0] velocity;
        logic [30:0] accel;
        logic [30:0] decel;
        logic        link_online;
        logic        fb_valid;
        logic [1:0]  fb_ready;
        logic        fb_not_following;
        logic        fb_reached;
        logic [31:0] fb_position;
    } t_cls_item;

    // Published command word
    typedef struct packed {
        logic [1:0]  mode;
        logic        clr;
        logic        acc_bit;
        logic [31:0] pos;
        logic [30:0] vel;
        logic [30:0] acc;
        logic [30:0] dec;
    } t_cmd;

endpackage

// ----- rtl/svam_if.sv -----
// Channel interfaces: event input, result output and configuration writes.
interface svam_in_if;
    logic                valid;
    logic                ready;
    svam_pkg::t_in_item  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface svam_out_if;
    logic                valid;
    logic                ready;
    svam_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface svam_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/svam_front.sv -----
// Front end: takes event beats, clamps and offsets the target, resolves the profile.
module svam_front (
    svam_in_if.sink              i_in,
    input  svam_pkg::t_cfg       i_cfg,
    output logic                 o_push_valid,
    output svam_pkg::t_cls_item  o_push_data,
    input  logic                 i_push_ready
);

    logic signed [31:0] lo_clamped;
    logic signed [31:0] clamped;

    // min first, then max, so max wins on crossed limits
    assign lo_clamped = (i_in.data.target_pos < i_cfg.min_position) ?
                        i_cfg.min_position : i_in.data.target_pos;
    assign clamped    = (lo_clamped > i_cfg.max_position) ? i_cfg.max_position : lo_clamped;

    always_comb begin
        o_push_data.action           = i_in.data.action;
        o_push_data.abs_target       = 32'(i_cfg.zero_offset) + 32'(clamped);
        o_push_data.velocity         = (i_in.data.move_speed != '0) ?
                                       i_in.data.move_speed : i_cfg.default_velocity;
        o_push_data.accel            = (i_in.data.move_accel != '0) ?
                                       i_in.data.move_accel : i_cfg.default_accel;
        o_push_data.decel            = (i_in.data.move_decel != '0) ?
                                       i_in.data.move_decel : i_cfg.default_decel;
        o_push_data.link_online      = i_in.data.link_online;
        o_push_data.fb_valid         = i_in.data.fb_valid;
        o_push_data.fb_ready         = i_in.data.fb_ready;
        o_push_data.fb_not_following = i_in.data.fb_not_following;
        o_push_data.fb_reached       = i_in.data.fb_reached;
        o_push_data.fb_position      = 32'(i_in.data.fb_position);
    end

    assign o_push_valid = i_in.valid;
    assign i_in.ready   = i_push_ready;

endmodule

// ----- rtl/svam_queue.sv -----
// Short FIFO between the front end and the sequencer core.
module svam_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push_valid,
    input  svam_pkg::t_cls_item  i_push_data,
    output logic                 o_push_ready,
    output logic                 o_pop_valid,
    output svam_pkg::t_cls_item  o_pop_data,
    input  logic                 i_pop_ready
);

    localparam int PTR_W = (svam_pkg::QUEUE_DEPTH > 1) ? $clog2(svam_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(svam_pkg::QUEUE_DEPTH + 1);

    svam_pkg::t_cls_item r_mem [svam_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                push, pop;

    assign o_push_ready = (r_count != CNT_W'(svam_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(svam_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(svam_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ----- rtl/svam_back.sv -----
// Sequencer core: arm and move phases, published command word, result register.
module svam_back #(
    parameter int CLEAR_FAULT_TICKS = 10,
    parameter int WAIT_READY_TICKS  = 300,
    parameter int PRELOAD_TICKS     = 4,
    parameter int RELEASE_TICKS     = 4,
    parameter int START_TICKS       = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  svam_pkg::t_cfg       i_cfg,
    input  logic                 i_pop_valid,
    input  svam_pkg::t_cls_item  i_pop_data,
    output logic                 o_pop_ready,
    svam_out_if.source           o_out
);

    localparam int AW = svam_pkg::ARM_CNT_W;
    localparam int MW = svam_pkg::MOVE_CNT_W;

    localparam logic [2:0] MV_IDLE    = 3'd0;
    localparam logic [2:0] MV_PRELOAD = 3'd1;
    localparam logic [2:0] MV_RELEASE = 3'd2;
    localparam logic [2:0] MV_START   = 3'd3;
    localparam logic [2:0] MV_RUN     = 3'd4;

    localparam logic [1:0] ARM_IDLE  = 2'd0;
    localparam logic [1:0] ARM_CLEAR = 2'd1;
    localparam logic [1:0] ARM_WAIT  = 2'd2;
    localparam logic [1:0] ARM_HOLD  = 2'd3;

    logic            r_init, n_init;
    logic            r_enabled, n_enabled;
    logic            r_stop, n_stop;
    logic            r_motion, n_motion;
    logic            r_toggle, n_toggle;
    logic [2:0]      r_mv, n_mv;
    logic [1:0]      r_arm, n_arm;
    logic [MW-1:0]   r_mv_cnt, n_mv_cnt;
    logic [AW-1:0]   r_arm_cnt, n_arm_cnt;
    logic [31:0]     r_target, n_target;
    logic [30:0]     r_vel, n_vel;
    logic [30:0]     r_acc, n_acc;
    logic [30:0]     r_dec, n_dec;
    svam_pkg::t_cmd  r_cmd, n_cmd;

    logic                 r_out_valid;
    svam_pkg::t_out_item  r_out_data, n_out_data;

    logic                 pop;
    logic                 in_op;
    logic [31:0]          act_pos;
    logic                 ok;
    logic                 busy;
    svam_pkg::t_cls_item  it;

    function automatic svam_pkg::t_cmd f_cmd(input logic [1:0] mode, input logic clr,
                                             input logic acc_bit, input logic [31:0] pos,
                                             input logic [30:0] vel, input logic [30:0] acc,
                                             input logic [30:0] dec);
        svam_pkg::t_cmd c;
        c.mode    = mode;
        c.clr     = clr;
        c.acc_bit = acc_bit;
        c.pos     = pos;
        c.vel     = vel;
        c.acc     = acc;
        c.dec     = dec;
        return c;
    endfunction

    assign o_pop_ready = !r_out_valid || o_out.ready;
    assign pop         = i_pop_valid && o_pop_ready;
    assign it          = i_pop_data;
    assign in_op       = it.fb_valid && (it.fb_ready == svam_pkg::FB_IN_OPERATION);
    assign act_pos     = it.fb_valid ? it.fb_position : r_target;

    always_comb begin
        n_init    = r_init;
        n_enabled = r_enabled;
        n_stop    = r_stop;
        n_motion  = r_motion;
        n_toggle  = r_toggle;
        n_mv      = r_mv;
        n_arm     = r_arm;
        n_mv_cnt  = r_mv_cnt;
        n_arm_cnt = r_arm_cnt;
        n_target  = r_target;
        n_vel     = r_vel;
        n_acc     = r_acc;
        n_dec     = r_dec;
        n_cmd     = r_cmd;
        ok        = 1'b1;

        case (it.action)
            svam_pkg::ACT_TICK: begin
                if (r_arm == ARM_CLEAR) begin
                    n_cmd     = f_cmd(svam_pkg::MODE_OFF, 1'b1, r_toggle, act_pos,
                                      i_cfg.default_velocity, i_cfg.default_accel,
                                      i_cfg.default_decel);
                    n_target  = act_pos;
                    n_arm_cnt = (r_arm_cnt != '0) ? r_arm_cnt - 1'b1 : '0;
                    if (n_arm_cnt == '0) begin
                        if (!r_enabled) begin
                            n_arm = ARM_IDLE;
                            n_cmd = f_cmd(svam_pkg::MODE_OFF, 1'b0, r_toggle, act_pos,
                                          i_cfg.default_velocity, i_cfg.default_accel,
                                          i_cfg.default_decel);
                        end else begin
                            n_arm     = ARM_WAIT;
                            n_arm_cnt = AW'(WAIT_READY_TICKS);
                            n_cmd     = f_cmd(svam_pkg::MODE_HALT, 1'b0, r_toggle, act_pos,
                                              i_cfg.default_velocity, i_cfg.default_accel,
                                              i_cfg.default_decel);
                        end
                    end
                end else if (r_arm == ARM_WAIT) begin
                    n_cmd     = f_cmd(svam_pkg::MODE_HALT, 1'b0, r_toggle, act_pos,
                                      i_cfg.default_velocity, i_cfg.default_accel,
                                      i_cfg.default_decel);
                    n_target  = act_pos;
                    n_arm_cnt = (r_arm_cnt != '0) ? r_arm_cnt - 1'b1 : '0;
                    if (in_op) begin
                        n_arm     = ARM_HOLD;
                        n_arm_cnt = '0;
                    end else if (n_arm_cnt == '0) begin
                        n_arm = ARM_HOLD;
                    end
                end else if (r_mv == MV_PRELOAD) begin
                    n_mv_cnt = (r_mv_cnt != '0) ? r_mv_cnt - 1'b1 : '0;
                    n_cmd    = f_cmd(svam_pkg::MODE_HALT, 1'b0, r_toggle, r_target,
                                     r_vel, r_acc, r_dec);
                    if (n_mv_cnt == '0) begin
                        n_mv     = MV_RELEASE;
                        n_mv_cnt = MW'(RELEASE_TICKS);
                        n_cmd    = f_cmd(svam_pkg::MODE_ENABLE, 1'b0, r_toggle, r_target,
                                         r_vel, r_acc, r_dec);
                    end
                end else if (r_mv == MV_RELEASE) begin
                    n_mv_cnt = (r_mv_cnt != '0) ? r_mv_cnt - 1'b1 : '0;
                    n_cmd    = f_cmd(svam_pkg::MODE_ENABLE, 1'b0, r_toggle, r_target,
                                     r_vel, r_acc, r_dec);
                    if (n_mv_cnt == '0 || (in_op && !it.fb_not_following)) begin
                        n_mv     = MV_START;
                        n_mv_cnt = MW'(START_TICKS);
                        n_toggle = !r_toggle;
                        n_cmd    = f_cmd(svam_pkg::MODE_ENABLE, 1'b0, !r_toggle, r_target,
                                         r_vel, r_acc, r_dec);
                    end
                end else if (r_mv == MV_START) begin
                    n_mv_cnt = (r_mv_cnt != '0) ? r_mv_cnt - 1'b1 : '0;
                    n_cmd    = f_cmd(svam_pkg::MODE_ENABLE, 1'b0, r_toggle, r_target,
                                     r_vel, r_acc, r_dec);
                    if (n_mv_cnt == '0) begin
                        n_mv = MV_RUN;
                    end
                end else if (r_motion && !r_stop && r_mv == MV_RUN) begin
                    n_cmd = f_cmd(svam_pkg::MODE_ENABLE, 1'b0, r_toggle, r_target,
                                  r_vel, r_acc, r_dec);
                    if (it.fb_valid && it.fb_reached) begin
                        n_motion = 1'b0;
                        n_mv     = MV_IDLE;
                        n_target = act_pos;
                        n_cmd    = f_cmd(svam_pkg::MODE_HALT, 1'b0, r_toggle, act_pos,
                                         i_cfg.default_velocity, i_cfg.default_accel,
                                         i_cfg.default_decel);
                    end
                end
            end
            svam_pkg::ACT_BEGIN: begin
                n_init = 1'b1;
                n_cmd  = '0;
            end
            svam_pkg::ACT_ENABLE, svam_pkg::ACT_CLEAR: begin
                if (it.action == svam_pkg::ACT_ENABLE && !r_init) begin
                    ok = 1'b0;
                end else begin
                    if (it.action == svam_pkg::ACT_ENABLE) begin
                        n_enabled = 1'b1;
                        n_stop    = 1'b0;
                    end
                    n_motion  = 1'b0;
                    n_mv      = MV_IDLE;
                    n_mv_cnt  = '0;
                    n_arm     = ARM_CLEAR;
                    n_arm_cnt = AW'(CLEAR_FAULT_TICKS);
                    n_target  = act_pos;
                    n_cmd     = f_cmd(svam_pkg::MODE_OFF, 1'b1, r_toggle, act_pos,
                                      i_cfg.default_velocity, i_cfg.default_accel,
                                      i_cfg.default_decel);
                end
            end
            svam_pkg::ACT_DISABLE: begin
                n_enabled = 1'b0;
                n_stop    = 1'b0;
                n_motion  = 1'b0;
                n_mv      = MV_IDLE;
                n_arm     = ARM_IDLE;
                n_arm_cnt = '0;
                n_target  = act_pos;
                n_cmd     = f_cmd(svam_pkg::MODE_OFF, 1'b0, r_toggle, act_pos,
                                  i_cfg.default_velocity, i_cfg.default_accel,
                                  i_cfg.default_decel);
            end
            svam_pkg::ACT_MOVE: begin
                if (!r_init || !r_enabled || !it.link_online) begin
                    ok = 1'b0;
                end else begin
                    n_stop    = 1'b0;
                    n_motion  = 1'b1;
                    n_arm     = ARM_HOLD;
                    n_arm_cnt = '0;
                    n_target  = it.abs_target;
                    n_vel     = it.velocity;
                    n_acc     = it.accel;
                    n_dec     = it.decel;
                    n_mv      = MV_PRELOAD;
                    n_mv_cnt  = MW'(PRELOAD_TICKS);
                    n_cmd     = f_cmd(svam_pkg::MODE_HALT, 1'b0, r_toggle, it.abs_target,
                                      it.velocity, it.accel, it.decel);
                end
            end
            svam_pkg::ACT_STOP: begin
                n_stop   = 1'b1;
                n_motion = 1'b0;
                n_mv     = MV_IDLE;
                n_cmd    = f_cmd(svam_pkg::MODE_HALT, 1'b0, r_toggle, act_pos,
                                 (r_vel != '0) ? r_vel : i_cfg.default_velocity,
                                 (r_acc != '0) ? r_acc : i_cfg.default_accel,
                                 (r_dec != '0) ? r_dec : i_cfg.default_decel);
            end
            default: begin
                ok = 1'b0;
            end
        endcase

        if (n_stop || !n_motion) begin
            busy = 1'b0;
        end else if (n_mv inside {MV_PRELOAD, MV_RELEASE, MV_START}) begin
            busy = 1'b1;
        end else begin
            busy = !(it.fb_valid && it.fb_reached);
        end

        n_out_data.drive_mode   = n_cmd.mode;
        n_out_data.clear_errors = n_cmd.clr;
        n_out_data.accept_level = n_cmd.acc_bit;
        n_out_data.cmd_position = signed'(n_cmd.pos);
        n_out_data.cmd_velocity = n_cmd.vel;
        n_out_data.cmd_accel    = n_cmd.acc;
        n_out_data.cmd_decel    = n_cmd.dec;
        n_out_data.accepted     = ok;
        n_out_data.busy_res     = busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init      <= 1'b0;
            r_enabled   <= 1'b0;
            r_stop      <= 1'b0;
            r_motion    <= 1'b0;
            r_toggle    <= 1'b0;
            r_mv        <= MV_IDLE;
            r_arm       <= ARM_IDLE;
            r_mv_cnt    <= '0;
            r_arm_cnt   <= '0;
            r_target    <= '0;
            r_vel       <= '0;
            r_acc       <= '0;
            r_dec       <= '0;
            r_cmd       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_init    <= n_init;
                r_enabled <= n_enabled;
                r_stop    <= n_stop;
                r_motion  <= n_motion;
                r_toggle  <= n_toggle;
                r_mv      <= n_mv;
                r_arm     <= n_arm;
                r_mv_cnt  <= n_mv_cnt;
                r_arm_cnt <= n_arm_cnt;
                r_target  <= n_target;
                r_vel     <= n_vel;
                r_acc     <= n_acc;
                r_dec     <= n_dec;
                r_cmd     <= n_cmd;
            end
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

endmodule

// ----- rtl/servo_axis_arm_move_sequencer.sv -----
// Top level of the servo axis arm/move sequencer: config registers, front, queue, core.
//
// Sequencer for a positioning servo drive. Each event beat on i_in (tick,
// begin, enable, disable, move, stop, clear alarm, plus the drive feedback
// sampled for it) yields exactly one result beat on o_out carrying the
// command word now published and the accepted/busy flags. Throughput is one
// beat per clock while o_out takes results: the front end clamps the target,
// adds the zero offset and resolves the move profile in the input cycle and
// writes a two-beat queue; the core pops one beat per clock, updating the
// arm/move phase state and loading the result register in the same cycle.
// A beat passes through the queue and then the result register. The core
// stalls while a result waits in the result register; when o_out stalls the
// queue fills and i_in.ready drops once it holds two beats. Configuration
// writes are always ready and are registered; change them only while no beat
// is in flight. Tick counts of the arm and move phases are set by parameters.
module servo_axis_arm_move_sequencer #(
    parameter int CLEAR_FAULT_TICKS = 10,
    parameter int WAIT_READY_TICKS  = 300,
    parameter int PRELOAD_TICKS     = 4,
    parameter int RELEASE_TICKS     = 4,
    parameter int START_TICKS       = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    svam_in_if.sink      i_in,
    svam_out_if.source   o_out,
    svam_cfg_if.sink     i_cfg
);

    svam_pkg::t_cfg       r_cfg;
    logic                 push_valid, push_ready;
    svam_pkg::t_cls_item  push_data;
    logic                 q_valid, q_ready;
    svam_pkg::t_cls_item  q_data;

    // Config writes never stall.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zero_offset      <= 32'sd0;
            r_cfg.min_position     <= 32'sh8000_0000;
            r_cfg.max_position     <= 32'sh7FFF_FFFF;
            r_cfg.default_velocity <= '0;
            r_cfg.default_accel    <= '0;
            r_cfg.default_decel    <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                svam_pkg::CFG_ZERO_OFFSET:  r_cfg.zero_offset      <= signed'(i_cfg.data);
                svam_pkg::CFG_MIN_POSITION: r_cfg.min_position     <= signed'(i_cfg.data);
                svam_pkg::CFG_MAX_POSITION: r_cfg.max_position     <= signed'(i_cfg.data);
                svam_pkg::CFG_DEF_VELOCITY: r_cfg.default_velocity <= i_cfg.data[30:0];
                svam_pkg::CFG_DEF_ACCEL:    r_cfg.default_accel    <= i_cfg.data[30:0];
                svam_pkg::CFG_DEF_DECEL:    r_cfg.default_decel    <= i_cfg.data[30:0];
                default: begin
                end
            endcase
        end
    end

    // Front end: classify and resolve each beat before queuing.
    svam_front u_front (
        .i_in         (i_in),
        .i_cfg        (r_cfg),
        .o_push_valid (push_valid),
        .o_push_data  (push_data),
        .i_push_ready (push_ready)
    );

    svam_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_data  (push_data),
        .o_push_ready (push_ready),
        .o_pop_valid  (q_valid),
        .o_pop_data   (q_data),
        .i_pop_ready  (q_ready)
    );

    // Core: phase state and the registered result beat.
    svam_back #(
        .CLEAR_FAULT_TICKS (CLEAR_FAULT_TICKS),
        .WAIT_READY_TICKS  (WAIT_READY_TICKS),
        .PRELOAD_TICKS     (PRELOAD_TICKS),
        .RELEASE_TICKS     (RELEASE_TICKS),
        .START_TICKS       (START_TICKS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_pop_valid (q_valid),
        .i_pop_data  (q_data),
        .o_pop_ready (q_ready),
        .o_out       (o_out)
    );

`ifndef NO_ASSERTIONS
    // Core never overwrites a result beat that is still stalled.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_valid && q_ready) |-> (!o_out.valid || o_out.ready))
        else $error("core popped while result register was stalled");

    // A queued beat moves on whenever the result slot is free.
    a_no_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_valid && (!o_out.valid || o_out.ready)) |-> q_ready)
        else $error("core idle with queued beat and free result slot");

    // Every popped beat shows up as a result next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_valid && q_ready) |=> o_out.valid)
        else $error("popped beat produced no result");
`endif

endmodule
